@@ src/epi_pkg.sv @@
// shared types and constants of the energy peak interpolator
package epi_pkg;

	// result field widths
	localparam int INDEX_W   = 12;
	localparam int FRAC_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int OUT_TDATA_W = 32;

	// fractional divide: one integer bit then this many fraction bits
	localparam int DIV_STEPS = 15;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// controller states
	typedef enum logic [2:0] {
		ST_RUN,
		ST_WAIT,
		ST_PREP,
		ST_INIT,
		ST_DIV,
		ST_DONE
	} state_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		PS_OK       = 2'd0,
		PS_EDGE     = 2'd1,
		PS_FLAT     = 2'd2,
		PS_OVERFLOW = 2'd3
	} peak_status_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;
		logic prep;
		logic init;
		logic step;
		logic load;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

@@ src/epi_ctrl.sv @@
// controller state machine of the energy peak interpolator
module epi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	output logic                s_tready,
	input  epi_pkg::dp_stat_t   stat,
	output epi_pkg::ctl_cmd_t   cmd
);

	epi_pkg::state_t state_q, state_d;
	logic [epi_pkg::CNT_W-1:0] cnt_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epi_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == epi_pkg::ST_INIT) begin
			cnt_q <= '0;
		end else if (state_q == epi_pkg::ST_DIV) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			epi_pkg::ST_RUN: begin
				if (s_tvalid && s_tlast) state_d = epi_pkg::ST_WAIT;
			end
			epi_pkg::ST_WAIT: state_d = epi_pkg::ST_PREP;
			epi_pkg::ST_PREP: state_d = epi_pkg::ST_INIT;
			epi_pkg::ST_INIT: state_d = epi_pkg::ST_DIV;
			epi_pkg::ST_DIV: begin
				if (cnt_q == epi_pkg::CNT_W'(epi_pkg::DIV_STEPS - 1)) state_d = epi_pkg::ST_DONE;
			end
			epi_pkg::ST_DONE: begin
				if (stat.out_free) state_d = epi_pkg::ST_RUN;
			end
			default: state_d = epi_pkg::ST_RUN;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			epi_pkg::ST_RUN: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			epi_pkg::ST_WAIT: ;
			epi_pkg::ST_PREP: cmd.prep = 1'b1;
			epi_pkg::ST_INIT: cmd.init = 1'b1;
			epi_pkg::ST_DIV:  cmd.step = 1'b1;
			epi_pkg::ST_DONE: cmd.load = stat.out_free;
			default: ;
		endcase
	end

endmodule

@@ src/epi_dp.sv @@
// datapath of the energy peak interpolator: energy, peak tracking, divider, result register
module epi_dp #(
	parameter int MAX_SAMPLES = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  epi_pkg::ctl_cmd_t                   cmd,
	output epi_pkg::dp_stat_t                   stat,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [epi_pkg::INDEX_W-1:0]         peak_index,
	output logic signed [epi_pkg::FRAC_W-1:0]   peak_fraction,
	output logic [epi_pkg::STATUS_W-1:0]        peak_status
);

	localparam int EW = 2 * SAMPLE_BITS - 1;
	localparam int CW = $clog2(MAX_SAMPLES + 2);
	localparam int IW = $clog2(MAX_SAMPLES);
	localparam int QW = epi_pkg::DIV_STEPS + 1;

	// energy stage
	logic [SAMPLE_BITS-1:0]   raw, mag;
	logic [2*SAMPLE_BITS-1:0] prod;
	logic [EW-1:0]            energy_s1;
	logic                     valid_s1;

	assign raw  = sample;
	assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
	assign prod = mag * mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) energy_s1 <= prod[EW-1:0];
	end

	// record tracking state
	logic [CW-1:0] count_q;
	logic [EW-1:0] prev_q, best_q, before_q, after_q;
	logic [IW-1:0] idx_q;
	logic          await_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			prev_q   <= '0;
			best_q   <= '0;
			before_q <= '0;
			after_q  <= '0;
			idx_q    <= '0;
			await_q  <= 1'b0;
		end else if (cmd.prep) begin
			count_q  <= '0;
			prev_q   <= '0;
			best_q   <= '0;
			before_q <= '0;
			after_q  <= '0;
			idx_q    <= '0;
			await_q  <= 1'b0;
		end else if (valid_s1) begin
			if (count_q < CW'(MAX_SAMPLES)) begin
				if (count_q == '0) begin
					best_q   <= energy_s1;
					idx_q    <= '0;
					before_q <= '0;
					after_q  <= '0;
					await_q  <= 1'b1;
				end else begin
					if (await_q) begin
						after_q <= energy_s1;
						await_q <= 1'b0;
					end
					if (energy_s1 > best_q) begin
						best_q   <= energy_s1;
						idx_q    <= count_q[IW-1:0];
						before_q <= prev_q;
						await_q  <= 1'b1;
					end
				end
				prev_q  <= energy_s1;
				count_q <= count_q + 1'b1;
			end else begin
				count_q <= CW'(MAX_SAMPLES + 1);
			end
		end
	end

	// curvature and slope of the parabola
	logic [EW:0]   den_w;
	logic [EW-1:0] num_w;
	logic          pos_w;
	epi_pkg::peak_status_t status_w;

	assign den_w = ({1'b0, best_q} - {1'b0, before_q}) + ({1'b0, best_q} - {1'b0, after_q});
	assign pos_w = after_q >= before_q;
	assign num_w = pos_w ? (after_q - before_q) : (before_q - after_q);

	always_comb begin
		if (count_q > CW'(MAX_SAMPLES)) begin
			status_w = epi_pkg::PS_OVERFLOW;
		end else if (idx_q == '0 || await_q) begin
			status_w = epi_pkg::PS_EDGE;
		end else if (den_w == '0) begin
			status_w = epi_pkg::PS_FLAT;
		end else begin
			status_w = epi_pkg::PS_OK;
		end
	end

	// captured record result
	logic [EW:0]           num_q, den_q, rem_q;
	logic                  pos_q;
	logic [IW-1:0]         ridx_q;
	epi_pkg::peak_status_t rstat_q;
	logic [QW-1:0]         quo_q;
	logic [EW+1:0]         two_r;
	logic [EW+1:0]         diff_w;

	assign two_r  = {rem_q, 1'b0};
	assign diff_w = two_r - {1'b0, den_q};

	// restoring fractional divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_q   <= {1'b0, num_w};
			den_q   <= den_w;
			pos_q   <= pos_w;
			ridx_q  <= idx_q;
			rstat_q <= status_w;
		end
		if (cmd.init) begin
			if (num_q >= den_q) begin
				quo_q <= QW'(1);
				rem_q <= '0;
			end else begin
				quo_q <= '0;
				rem_q <= num_q;
			end
		end else if (cmd.step) begin
			if (two_r >= {1'b0, den_q}) begin
				rem_q <= diff_w[EW:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= two_r[EW:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	// rounding and sign of the offset
	logic [QW:0]                       quo_inc;
	logic [epi_pkg::FRAC_W-1:0]        frac_mag, frac_w;

	assign quo_inc  = {1'b0, quo_q} + 1'b1;
	assign frac_mag = epi_pkg::FRAC_W'(quo_inc >> 1);
	assign frac_w   = (rstat_q != epi_pkg::PS_OK) ? '0 :
		(pos_q ? frac_mag : (~frac_mag + 1'b1));

	// result register
	logic                               mv_q;
	logic [epi_pkg::INDEX_W-1:0]        pi_q;
	logic [epi_pkg::FRAC_W-1:0]         pf_q;
	epi_pkg::peak_status_t              ps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (cmd.load) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pi_q <= epi_pkg::INDEX_W'(ridx_q);
			pf_q <= frac_w;
			ps_q <= rstat_q;
		end
	end

	assign stat.out_free = !mv_q || m_tready;
	assign m_tvalid      = mv_q;
	assign peak_index    = pi_q;
	assign peak_fraction = pf_q;
	assign peak_status   = ps_q;

`ifndef ASSERT_OFF
	// any non-ok result carries a zero offset
	a_frac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mv_q && ps_q != epi_pkg::PS_OK) |-> (pf_q == '0))
		else $error("non-ok result with nonzero fraction");

	// offset stays within half a sample
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		mv_q |-> ($signed(pf_q) <= 16'sd16384 && $signed(pf_q) >= -16'sd16384))
		else $error("fraction out of range");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (den_q == '0 || rem_q < den_q))
		else $error("divider remainder not below divisor");
`endif

endmodule

@@ src/energy_peak_interpolator.sv @@
// Path from last sample accepted to result valid: squaring stage, tracking update,
// slope/curvature capture, divider setup, 15 divide steps, result load.
// Throughput: one sample per cycle within a record; the input is not ready while the
// 15-step serial divider runs. The result register frees the input while a
// result waits. Asynchronous active-low reset clears the record state and the valid flag.
// top level of the energy peak interpolator
module energy_peak_interpolator #(
	parameter int MAX_SAMPLES = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata, // sample
	input  logic                                    s_tlast,  // last
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [epi_pkg::OUT_TDATA_W-1:0]         m_tdata   // peak_index, peak_fraction, peak_status
);

	epi_pkg::ctl_cmd_t cmd;
	epi_pkg::dp_stat_t stat;

	logic [epi_pkg::INDEX_W-1:0]       peak_index;
	logic signed [epi_pkg::FRAC_W-1:0] peak_fraction;
	logic [epi_pkg::STATUS_W-1:0]      peak_status;

	// sequencer
	epi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	epi_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (s_tdata[SAMPLE_BITS-1:0]),
		.cmd           (cmd),
		.stat          (stat),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.peak_index    (peak_index),
		.peak_fraction (peak_fraction),
		.peak_status   (peak_status)
	);

	// result packing, lowest field first
	assign m_tdata = {2'b00, peak_status, peak_fraction, peak_index};

endmodule
